@@ src/triangle_tangent_frame_macros.svh @@
// Assertion macros of the triangle tangent frame checker.
`ifndef TRIANGLE_TANGENT_FRAME_MACROS_SVH
`define TRIANGLE_TANGENT_FRAME_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define TTF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define TTF_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ttf_pkg.sv @@
// Widths, constants and control types of the triangle tangent frame block.
package ttf_pkg;

    localparam int POS_W   = 24;            // Q12.12 corner position
    localparam int TEX_W   = 16;            // Q2.14 texture coordinate
    localparam int NRM_W   = 16;            // Q1.14 normal
    localparam int OUT_W   = 32;            // Q16.16 result
    localparam int DP_W    = POS_W + 1;     // position delta
    localparam int DT_W    = TEX_W + 1;     // texcoord delta
    localparam int MA_W    = OUT_W + 1;     // multiplier operand a
    localparam int MB_W    = DT_W;          // multiplier operand b
    localparam int PROD_W  = MA_W + MB_W;   // product
    localparam int ACC_W   = PROD_W + 1;    // difference of two products
    localparam int NUM_W   = DP_W + DT_W + 1;
    localparam int DET_W   = 2 * DT_W + 1;
    localparam int TAN_SH  = 18;            // Q.26 / Q.28 -> Q.16
    localparam int Q_BITS  = OUT_W - 1;     // quotient bits below saturation
    localparam int DIV_W   = DET_W + Q_BITS + 1;
    localparam int CNT_W   = 5;
    localparam int RND_SH  = 14;            // Q.30 -> Q.16

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic valid;    // issue a product this cycle
        logic sub;      // subtract it from the running value
    } t_mac_ctl;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [DET_W-1:0] det;
    } t_div_ctl;

    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] quot;
    } t_div_stat;

endpackage

@@ src/ttf_if.sv @@
// Corner and frame channel interfaces of the triangle tangent frame block.
interface ttf_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [ttf_pkg::POS_W-1:0] pos_x;
    logic signed [ttf_pkg::POS_W-1:0] pos_y;
    logic signed [ttf_pkg::POS_W-1:0] pos_z;
    logic signed [ttf_pkg::TEX_W-1:0] tex_u;
    logic signed [ttf_pkg::TEX_W-1:0] tex_v;
    logic signed [ttf_pkg::NRM_W-1:0] norm_x;
    logic signed [ttf_pkg::NRM_W-1:0] norm_y;
    logic signed [ttf_pkg::NRM_W-1:0] norm_z;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, output ready);
endinterface

interface ttf_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ttf_pkg::OUT_W-1:0] tangent_x;
    logic signed [ttf_pkg::OUT_W-1:0] tangent_y;
    logic signed [ttf_pkg::OUT_W-1:0] tangent_z;
    logic signed [ttf_pkg::OUT_W-1:0] bitangent_x;
    logic signed [ttf_pkg::OUT_W-1:0] bitangent_y;
    logic signed [ttf_pkg::OUT_W-1:0] bitangent_z;
    logic                             degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, output ready);
endinterface

@@ src/ttf_mac.sv @@
// Shared signed multiplier with a registered product and a two-term accumulator.
module ttf_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic signed [ttf_pkg::MA_W-1:0]  i_a,
    input  logic signed [ttf_pkg::MB_W-1:0]  i_b,
    input  ttf_pkg::t_mac_ctl                i_ctl,
    output logic signed [ttf_pkg::ACC_W-1:0] o_acc
);

    logic signed [ttf_pkg::PROD_W-1:0] r_prod;
    logic signed [ttf_pkg::ACC_W-1:0]  r_acc;
    logic                              r_pv;
    logic                              r_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= i_a * i_b;
            r_sub  <= i_ctl.sub;
        end
        // first term loads, second term subtracts
        if (r_pv) begin
            if (r_sub) begin
                r_acc <= r_acc - ttf_pkg::ACC_W'(r_prod);
            end else begin
                r_acc <= ttf_pkg::ACC_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

@@ src/ttf_div.sv @@
// Radix-2 restoring divider: rounded, sign-applied and saturated tangent quotient.
module ttf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ttf_pkg::t_div_ctl  i_ctl,
    output ttf_pkg::t_div_stat o_stat
);

    logic [ttf_pkg::NUM_W-1:0]        w_nmag;
    logic [ttf_pkg::DET_W-1:0]        w_dmag;
    logic [ttf_pkg::DIV_W-1:0]        w_dividend;
    logic [ttf_pkg::DIV_W-1:0]        w_dsh0;
    logic                             w_ge;
    logic                             w_first;
    logic                             w_last;
    logic signed [ttf_pkg::OUT_W-1:0] w_qs;

    logic [ttf_pkg::DIV_W-1:0]  r_rem;
    logic [ttf_pkg::DIV_W-1:0]  r_dsh;
    logic [ttf_pkg::CNT_W-1:0]  r_cnt;
    logic [ttf_pkg::Q_BITS-1:0] r_q;
    logic                       r_sat;
    logic                       r_neg;
    logic                       r_busy;
    logic                       r_done;

    assign w_nmag = i_ctl.num[ttf_pkg::NUM_W-1] ? ttf_pkg::NUM_W'(-i_ctl.num)
                                                : ttf_pkg::NUM_W'(i_ctl.num);
    assign w_dmag = i_ctl.det[ttf_pkg::DET_W-1] ? ttf_pkg::DET_W'(-i_ctl.det)
                                                : ttf_pkg::DET_W'(i_ctl.det);
    // add half the divisor up front so the floor quotient rounds to nearest
    assign w_dividend = ttf_pkg::DIV_W'({w_nmag, {ttf_pkg::TAN_SH{1'b0}}})
                      + ttf_pkg::DIV_W'(w_dmag >> 1);
    assign w_dsh0 = ttf_pkg::DIV_W'({w_dmag, {ttf_pkg::Q_BITS{1'b0}}});

    assign w_ge    = (r_rem >= r_dsh);
    assign w_first = (r_cnt == ttf_pkg::CNT_W'(ttf_pkg::Q_BITS));
    assign w_last  = (w_first && w_ge) || (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= w_dividend;
            r_dsh <= w_dsh0;
            r_cnt <= ttf_pkg::CNT_W'(ttf_pkg::Q_BITS);
            r_q   <= '0;
            r_sat <= 1'b0;
            // r = -1/det: negative when numerator and det share a sign
            r_neg <= (i_ctl.num[ttf_pkg::NUM_W-1] == i_ctl.det[ttf_pkg::DET_W-1])
                     && (i_ctl.num != '0);
        end else if (r_busy) begin
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
            if (w_first) begin
                // quotient reaches 2^31: saturate and stop
                r_sat <= w_ge;
            end else begin
                r_q <= {r_q[ttf_pkg::Q_BITS-2:0], w_ge};
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
            end
        end
    end

    assign w_qs = ttf_pkg::OUT_W'({1'b0, r_q});

    always_comb begin
        o_stat.done = r_done;
        if (r_sat) begin
            o_stat.quot = r_neg ? ttf_pkg::OUT_MIN : ttf_pkg::OUT_MAX;
        end else begin
            o_stat.quot = r_neg ? -w_qs : w_qs;
        end
    end

endmodule

@@ src/triangle_tangent_frame.sv @@
// Top level of the triangle tangent frame block: corner store, sequencer, output register.
//
// Usage
//   i_corner carries one triangle corner per item (position Q12.12, texcoord Q2.14,
//   normal Q1.14). Send corners A, B, C in order; only B's normal is used.
//   o_frame carries one item per triangle: tangent and bitangent (N x T) in Q16.16,
//   saturated, and a degenerate flag that is set with all-zero vectors when the
//   UV determinant is zero.
// Sequence
//   Corners A and B are stored as they arrive. Corner C starts a sequence on one shared
//   33x17 multiplier and one radix-2 divider: the determinant, then each of three
//   numerators followed by its division (which ends early on saturation), then three
//   cross components, then the load of the output register. A degenerate triangle
//   goes from the determinant straight to that load. The divider makes one quotient
//   bit per cycle; no corner of the next triangle is taken until the result of the
//   last one is loaded.
// Reset and stall
//   Synchronous active-low reset empties the output register and restarts the
//   corner count at A. i_corner.ready is high only while no triangle is in work.
//   The output register holds its item while o_frame.ready is low; corners of the
//   next triangle are still taken, and its finished result waits until the held
//   item is gone.
module triangle_tangent_frame (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttf_in_if.sink     i_corner,
    ttf_out_if.source  o_frame
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    // jobs of the shared multiplier
    localparam logic [2:0] JOB_DET  = 3'd0;
    localparam logic [2:0] JOB_NUM0 = 3'd1;
    localparam logic [2:0] JOB_NUM1 = 3'd2;
    localparam logic [2:0] JOB_NUM2 = 3'd3;
    localparam logic [2:0] JOB_CRS0 = 3'd4;
    localparam logic [2:0] JOB_CRS1 = 3'd5;
    localparam logic [2:0] JOB_CRS2 = 3'd6;

    localparam logic [1:0] PH_USE = 2'd3;

    localparam logic [1:0] CNT_A = 2'd0;
    localparam logic [1:0] CNT_B = 2'd1;
    localparam logic [1:0] CNT_C = 2'd2;

    localparam logic [ttf_pkg::ACC_W-1:0] RND_HALF =
        ttf_pkg::ACC_W'(1) << (ttf_pkg::RND_SH - 1);
    localparam logic [ttf_pkg::ACC_W-1:0] SAT_LIM =
        ttf_pkg::ACC_W'({1'b1, {(ttf_pkg::OUT_W-1){1'b0}}});

    // control
    logic [1:0] r_state;
    logic [1:0] r_count;
    logic [2:0] r_job;
    logic [1:0] r_phase;
    logic       r_out_valid;

    // held corners A and B
    logic signed [ttf_pkg::POS_W-1:0] r_pa [3];
    logic signed [ttf_pkg::POS_W-1:0] r_pb [3];
    logic signed [ttf_pkg::TEX_W-1:0] r_ta [2];
    logic signed [ttf_pkg::TEX_W-1:0] r_tb [2];
    logic signed [ttf_pkg::NRM_W-1:0] r_nb [3];

    // edge deltas relative to B
    logic signed [ttf_pkg::DP_W-1:0] r_dp1 [3];
    logic signed [ttf_pkg::DP_W-1:0] r_dp2 [3];
    logic signed [ttf_pkg::DT_W-1:0] r_dt1u;
    logic signed [ttf_pkg::DT_W-1:0] r_dt1v;
    logic signed [ttf_pkg::DT_W-1:0] r_dt2u;
    logic signed [ttf_pkg::DT_W-1:0] r_dt2v;

    // working results
    logic signed [ttf_pkg::DET_W-1:0] r_det;
    logic signed [ttf_pkg::OUT_W-1:0] r_tan [3];
    logic signed [ttf_pkg::OUT_W-1:0] r_bit [3];
    logic                             r_degen;

    // output register
    logic signed [ttf_pkg::OUT_W-1:0] r_o_tan [3];
    logic signed [ttf_pkg::OUT_W-1:0] r_o_bit [3];
    logic                             r_o_degen;

    logic signed [ttf_pkg::POS_W-1:0] w_pin [3];
    logic signed [ttf_pkg::MA_W-1:0]  w_a;
    logic signed [ttf_pkg::MB_W-1:0]  w_b;
    logic signed [ttf_pkg::ACC_W-1:0] w_acc;
    logic                             w_in_acc;
    logic                             w_use;
    logic                             w_is_num;
    logic                             w_load_out;
    logic [1:0]                       w_ni;
    logic [1:0]                       w_ci;
    ttf_pkg::t_mac_ctl                w_mac_ctl;
    ttf_pkg::t_div_ctl                w_div_ctl;
    ttf_pkg::t_div_stat               w_div_stat;

    // Round a Q.30 difference to Q.16, ties away from zero, then saturate.
    function automatic logic signed [ttf_pkg::OUT_W-1:0] f_round_sat(
        input logic signed [ttf_pkg::ACC_W-1:0] p
    );
        logic [ttf_pkg::ACC_W-1:0]        mag;
        logic [ttf_pkg::ACC_W-1:0]        m;
        logic signed [ttf_pkg::OUT_W-1:0] res;
        mag = p[ttf_pkg::ACC_W-1] ? ttf_pkg::ACC_W'(-p) : ttf_pkg::ACC_W'(p);
        m   = (mag + RND_HALF) >> ttf_pkg::RND_SH;
        if (p[ttf_pkg::ACC_W-1]) begin
            res = (m >= SAT_LIM) ? ttf_pkg::OUT_MIN : -ttf_pkg::OUT_W'(m);
        end else begin
            res = (m >= SAT_LIM) ? ttf_pkg::OUT_MAX : ttf_pkg::OUT_W'(m);
        end
        return res;
    endfunction

    assign w_pin[0] = i_corner.pos_x;
    assign w_pin[1] = i_corner.pos_y;
    assign w_pin[2] = i_corner.pos_z;

    assign i_corner.ready = (r_state == ST_IDLE);
    assign w_in_acc       = i_corner.valid & i_corner.ready;

    assign w_use      = (r_state == ST_MUL) && (r_phase == PH_USE);
    assign w_is_num   = (r_job >= JOB_NUM0) && (r_job <= JOB_NUM2);
    assign w_ni       = 2'(r_job - JOB_NUM0);
    assign w_ci       = 2'(r_job - JOB_CRS0);
    assign w_load_out = (r_state == ST_WAIT) && (!r_out_valid || o_frame.ready);

    // Operand select: phase 0 issues the first product, phase 1 the subtracted one.
    always_comb begin
        case (r_job)
            JOB_DET: begin
                w_a = r_phase[0] ? ttf_pkg::MA_W'(r_dt1v) : ttf_pkg::MA_W'(r_dt1u);
                w_b = r_phase[0] ? r_dt2u : r_dt2v;
            end
            JOB_NUM0, JOB_NUM1, JOB_NUM2: begin
                w_a = r_phase[0] ? ttf_pkg::MA_W'(r_dp2[w_ni])
                                 : ttf_pkg::MA_W'(r_dp1[w_ni]);
                w_b = r_phase[0] ? r_dt1v : r_dt2v;
            end
            JOB_CRS0: begin
                // ny*tz - nz*ty
                w_a = r_phase[0] ? ttf_pkg::MA_W'(r_tan[1]) : ttf_pkg::MA_W'(r_tan[2]);
                w_b = r_phase[0] ? ttf_pkg::MB_W'(r_nb[2]) : ttf_pkg::MB_W'(r_nb[1]);
            end
            JOB_CRS1: begin
                // nz*tx - nx*tz
                w_a = r_phase[0] ? ttf_pkg::MA_W'(r_tan[2]) : ttf_pkg::MA_W'(r_tan[0]);
                w_b = r_phase[0] ? ttf_pkg::MB_W'(r_nb[0]) : ttf_pkg::MB_W'(r_nb[2]);
            end
            JOB_CRS2: begin
                // nx*ty - ny*tx
                w_a = r_phase[0] ? ttf_pkg::MA_W'(r_tan[0]) : ttf_pkg::MA_W'(r_tan[1]);
                w_b = r_phase[0] ? ttf_pkg::MB_W'(r_nb[1]) : ttf_pkg::MB_W'(r_nb[0]);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_mac_ctl.valid = (r_state == ST_MUL) && !r_phase[1];
    assign w_mac_ctl.sub   = r_phase[0];

    assign w_div_ctl.start = w_use && w_is_num;
    assign w_div_ctl.num   = w_acc[ttf_pkg::NUM_W-1:0];
    assign w_div_ctl.det   = r_det;

    ttf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_ctl   (w_mac_ctl),
        .o_acc   (w_acc)
    );

    ttf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .o_stat  (w_div_stat)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= CNT_A;
            r_job       <= JOB_DET;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished result, else drop the held item once taken
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.valid && o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (r_count)
                            CNT_A:   r_count <= CNT_B;
                            CNT_B:   r_count <= CNT_C;
                            default: begin
                                r_count <= CNT_A;
                                r_state <= ST_MUL;
                                r_job   <= JOB_DET;
                                r_phase <= '0;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    r_phase <= r_phase + 1'b1;
                    if (r_phase == PH_USE) begin
                        if (r_job == JOB_DET) begin
                            if (w_acc == '0) begin
                                r_state <= ST_WAIT;
                            end else begin
                                r_job <= JOB_NUM0;
                            end
                        end else if (w_is_num) begin
                            r_state <= ST_DIV;
                        end else if (r_job == JOB_CRS2) begin
                            r_state <= ST_WAIT;
                        end else begin
                            r_job <= r_job + 1'b1;
                        end
                    end
                end
                ST_DIV: begin
                    // advance to the next numerator, or to the cross terms after the last
                    if (w_div_stat.done) begin
                        r_job   <= r_job + 1'b1;
                        r_state <= ST_MUL;
                    end
                end
                ST_WAIT: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Corner store, deltas and working results.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            case (r_count)
                CNT_A: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pa[i] <= w_pin[i];
                    end
                    r_ta[0] <= i_corner.tex_u;
                    r_ta[1] <= i_corner.tex_v;
                end
                CNT_B: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pb[i] <= w_pin[i];
                    end
                    r_tb[0] <= i_corner.tex_u;
                    r_tb[1] <= i_corner.tex_v;
                    r_nb[0] <= i_corner.norm_x;
                    r_nb[1] <= i_corner.norm_y;
                    r_nb[2] <= i_corner.norm_z;
                end
                default: begin
                    for (int i = 0; i < 3; i++) begin
                        r_dp1[i] <= ttf_pkg::DP_W'(r_pa[i]) - ttf_pkg::DP_W'(r_pb[i]);
                        r_dp2[i] <= ttf_pkg::DP_W'(w_pin[i]) - ttf_pkg::DP_W'(r_pb[i]);
                    end
                    r_dt1u <= ttf_pkg::DT_W'(r_ta[0]) - ttf_pkg::DT_W'(r_tb[0]);
                    r_dt1v <= ttf_pkg::DT_W'(r_ta[1]) - ttf_pkg::DT_W'(r_tb[1]);
                    r_dt2u <= ttf_pkg::DT_W'(i_corner.tex_u) - ttf_pkg::DT_W'(r_tb[0]);
                    r_dt2v <= ttf_pkg::DT_W'(i_corner.tex_v) - ttf_pkg::DT_W'(r_tb[1]);
                end
            endcase
        end

        if (w_use) begin
            if (r_job == JOB_DET) begin
                r_det   <= w_acc[ttf_pkg::DET_W-1:0];
                r_degen <= (w_acc == '0);
                if (w_acc == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_tan[i] <= '0;
                        r_bit[i] <= '0;
                    end
                end
            end else if (!w_is_num) begin
                r_bit[w_ci] <= f_round_sat(w_acc);
            end
        end

        if ((r_state == ST_DIV) && w_div_stat.done) begin
            r_tan[w_ni] <= w_div_stat.quot;
        end

        if (w_load_out) begin
            for (int i = 0; i < 3; i++) begin
                r_o_tan[i] <= r_tan[i];
                r_o_bit[i] <= r_bit[i];
            end
            r_o_degen <= r_degen;
        end
    end

    assign o_frame.valid       = r_out_valid;
    assign o_frame.tangent_x   = r_o_tan[0];
    assign o_frame.tangent_y   = r_o_tan[1];
    assign o_frame.tangent_z   = r_o_tan[2];
    assign o_frame.bitangent_x = r_o_bit[0];
    assign o_frame.bitangent_y = r_o_bit[1];
    assign o_frame.bitangent_z = r_o_bit[2];
    assign o_frame.degenerate  = r_o_degen;

endmodule

@@ src/ttf_checker.sv @@
// Port-level checker of the triangle tangent frame block and its bind.
`include "triangle_tangent_frame_macros.svh"

module ttf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic                             i_degenerate,
    input logic signed [ttf_pkg::OUT_W-1:0] i_tan_x,
    input logic signed [ttf_pkg::OUT_W-1:0] i_tan_y,
    input logic signed [ttf_pkg::OUT_W-1:0] i_tan_z,
    input logic signed [ttf_pkg::OUT_W-1:0] i_bit_x,
    input logic signed [ttf_pkg::OUT_W-1:0] i_bit_y,
    input logic signed [ttf_pkg::OUT_W-1:0] i_bit_z
);

    logic w_in_acc;
    logic w_zero;

    assign w_in_acc = i_in_valid && i_in_ready;
    assign w_zero   = (i_tan_x == '0) && (i_tan_y == '0) && (i_tan_z == '0)
                   && (i_bit_x == '0) && (i_bit_y == '0) && (i_bit_z == '0);

    // reset empties the output register
    `TTF_ASSERT_RST(a_rst_empty, !i_rst_n, !i_out_valid, "output valid after reset")

    // a degenerate triangle carries zero vectors
    `TTF_ASSERT_NOW(a_degen_zero, i_out_valid && i_degenerate, w_zero,
                    "degenerate item with nonzero vectors")

    // a new result is only loaded from the busy sequence, never while corners are taken
    `TTF_ASSERT_NOW(a_load_busy, $rose(i_out_valid), $past(!i_in_ready) && !$past(w_in_acc),
                    "result appeared without a finished sequence")

    // a stalled item holds: valid, the degenerate flag, tangent x and bitangent z are checked
    `TTF_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_degenerate) && $stable(i_tan_x)
                     && $stable(i_bit_z), "stalled output item changed")

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_corner.valid),
    .i_in_ready   (i_corner.ready),
    .i_out_valid  (o_frame.valid),
    .i_out_ready  (o_frame.ready),
    .i_degenerate (o_frame.degenerate),
    .i_tan_x      (o_frame.tangent_x),
    .i_tan_y      (o_frame.tangent_y),
    .i_tan_z      (o_frame.tangent_z),
    .i_bit_x      (o_frame.bitangent_x),
    .i_bit_y      (o_frame.bitangent_y),
    .i_bit_z      (o_frame.bitangent_z)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the triangle tangent frame block.
module testbench;

    localparam int POS_W  = ttf_pkg::POS_W;
    localparam int TEX_W  = ttf_pkg::TEX_W;
    localparam int NRM_W  = ttf_pkg::NRM_W;
    localparam int OUT_W  = ttf_pkg::OUT_W;
    localparam int TAN_SH = ttf_pkg::TAN_SH;
    localparam int RND_SH = ttf_pkg::RND_SH;
    localparam logic signed [OUT_W-1:0] OUT_MIN = ttf_pkg::OUT_MIN;
    localparam logic signed [OUT_W-1:0] OUT_MAX = ttf_pkg::OUT_MAX;

    localparam int POS_HI  = (1 << (POS_W - 1)) - 1;
    localparam int POS_LO  = -(1 << (POS_W - 1));
    localparam int TEX_HI  = (1 << (TEX_W - 1)) - 1;
    localparam int TEX_LO  = -(1 << (TEX_W - 1));
    localparam int NRM_ONE = 1 << (NRM_W - 2);      // 1.0 in Q1.14
    localparam int SMALL_POS = 1 << 16;             // +-16.0 in Q12.12

    localparam int ITEMS_PHASE_1 = 420;
    localparam int ITEMS_PHASE_2 = 835;
    localparam int ITEMS_TOTAL   = 1250;
    localparam int HOLD_CYCLES   = 1500;            // long output stall
    localparam int STALL_LIMIT   = 6000;            // cycles with no item moving
    localparam int DRAIN_CYCLES  = 200;             // extra wait once no frame is pending

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
        logic signed [TEX_W-1:0] tex_u, tex_v;
        logic signed [NRM_W-1:0] norm_x, norm_y, norm_z;
    } t_corner;

    typedef struct packed {
        logic signed [OUT_W-1:0] tan_x, tan_y, tan_z;
        logic signed [OUT_W-1:0] bit_x, bit_y, bit_z;
        logic                    degenerate;
    } t_frame;

    typedef struct packed {
        t_corner c;
        logic    typed;     // use the frame below instead of the predictor
        t_frame  want;
    } t_stim_row;

    localparam t_frame NO_FRAME         = '0;
    localparam t_frame DEGENERATE_FRAME = '{32'sd0, 32'sd0, 32'sd0,
                                            32'sd0, 32'sd0, 32'sd0, 1'b1};
    localparam t_frame SATURATED_FRAME  = '{OUT_MIN, OUT_MIN, OUT_MIN,
                                            OUT_MAX, OUT_MAX, OUT_MIN, 1'b0};

    logic i_clk;
    logic i_rst_n;

    ttf_in_if  corner_if ();
    ttf_out_if frame_if ();

    triangle_tangent_frame dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_corner(corner_if),
        .o_frame (frame_if)
    );

    // Predictor state: corners held for the triangle in progress.
    logic [1:0]              corners_held;
    logic signed [POS_W-1:0] a_pos [3];
    logic signed [POS_W-1:0] b_pos [3];
    logic signed [TEX_W-1:0] a_tex [2];
    logic signed [TEX_W-1:0] b_tex [2];
    logic signed [NRM_W-1:0] b_norm [3];

    t_frame pending_frames [$];
    t_stim_row directed_rows [$];

    int    errors;
    int    corners_taken;
    int    frames_checked;
    int    degenerate_seen;
    int    saturated_seen;
    int    send_idle_pct;
    int    recv_idle_pct;
    bit    hold_request;
    string field_name [7] = '{"tangent_x", "tangent_y", "tangent_z", "bitangent_x",
                              "bitangent_y", "bitangent_z", "degenerate"};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_error(string msg);
        errors++;
        $display("ERROR frame %0d: %s", frames_checked, msg);
    endtask

    // Append one row to the directed table.
    function automatic void add_row(t_corner c, bit typed, t_frame want);
        directed_rows.insert(directed_rows.size(), t_stim_row'{c, typed, want});
    endfunction

    // Apply the sign and clamp to the 32-bit result range.
    function automatic logic signed [OUT_W-1:0] saturate(longint unsigned m, bit neg);
        if (neg)
            return (m >= 64'h8000_0000) ? OUT_MIN : OUT_W'(-longint'(m));
        return (m > 64'h7FFF_FFFF) ? OUT_MAX : OUT_W'(m);
    endfunction

    // Tangent component: -(num << 18) / det, rounded half away from zero.
    function automatic logic signed [OUT_W-1:0] tangent_div(longint num, longint det);
        longint unsigned n_mag, d_mag, q;
        n_mag = (num < 0) ? -num : num;
        n_mag = n_mag << TAN_SH;
        d_mag = (det < 0) ? -det : det;
        q = (n_mag + d_mag / 2) / d_mag;
        return saturate(q, ((num < 0) == (det < 0)) && num != 0);
    endfunction

    // One component of N x T, Q.30 back to Q.16 with rounding.
    function automatic logic signed [OUT_W-1:0] cross_term(longint n1, longint t1,
                                                           longint n2, longint t2);
        longint          p;
        longint unsigned m;
        p = n1 * t1 - n2 * t2;
        m = (p < 0) ? -p : p;
        m = (m + (64'd1 << (RND_SH - 1))) >> RND_SH;
        return saturate(m, p < 0);
    endfunction

    // Advance the corner count; return 1 with the frame on every third corner.
    function automatic bit frame_for_corner(t_corner c, output t_frame f);
        longint                  dp1 [3];
        longint                  dp2 [3];
        longint                  d1u, d1v, d2u, d2v, det;
        logic signed [POS_W-1:0] cp [3];
        logic signed [OUT_W-1:0] t [3];
        f = NO_FRAME;
        cp = '{c.pos_x, c.pos_y, c.pos_z};
        if (corners_held == 0) begin
            a_pos = cp;
            a_tex = '{c.tex_u, c.tex_v};
            corners_held = 1;
            return 1'b0;
        end
        if (corners_held == 1) begin
            b_pos  = cp;
            b_tex  = '{c.tex_u, c.tex_v};
            b_norm = '{c.norm_x, c.norm_y, c.norm_z};
            corners_held = 2;
            return 1'b0;
        end
        corners_held = 0;
        for (int i = 0; i < 3; i++) begin
            dp1[i] = longint'(a_pos[i]) - longint'(b_pos[i]);
            dp2[i] = longint'(cp[i]) - longint'(b_pos[i]);
        end
        d1u = longint'(a_tex[0]) - longint'(b_tex[0]);
        d1v = longint'(a_tex[1]) - longint'(b_tex[1]);
        d2u = longint'(c.tex_u) - longint'(b_tex[0]);
        d2v = longint'(c.tex_v) - longint'(b_tex[1]);
        det = d1u * d2v - d1v * d2u;
        if (det == 0) begin
            f.degenerate = 1'b1;
            return 1'b1;
        end
        for (int i = 0; i < 3; i++)
            t[i] = tangent_div(dp1[i] * d2v - dp2[i] * d1v, det);
        f.tan_x = t[0];
        f.tan_y = t[1];
        f.tan_z = t[2];
        f.bit_x = cross_term(b_norm[1], t[2], b_norm[2], t[1]);
        f.bit_y = cross_term(b_norm[2], t[0], b_norm[0], t[2]);
        f.bit_z = cross_term(b_norm[0], t[1], b_norm[1], t[0]);
        return 1'b1;
    endfunction

    function automatic t_corner corner(int px, int py, int pz, int tu, int tv,
                                       int nx, int ny, int nz);
        t_corner c;
        c.pos_x  = POS_W'(px);
        c.pos_y  = POS_W'(py);
        c.pos_z  = POS_W'(pz);
        c.tex_u  = TEX_W'(tu);
        c.tex_v  = TEX_W'(tv);
        c.norm_x = NRM_W'(nx);
        c.norm_y = NRM_W'(ny);
        c.norm_z = NRM_W'(nz);
        return c;
    endfunction

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int pick_extreme(int lo, int hi);
        case ($urandom_range(4))
            0: return lo;
            1: return hi;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    task automatic drive_corner(t_corner c);
        corner_if.pos_x  <= c.pos_x;
        corner_if.pos_y  <= c.pos_y;
        corner_if.pos_z  <= c.pos_z;
        corner_if.tex_u  <= c.tex_u;
        corner_if.tex_v  <= c.tex_v;
        corner_if.norm_x <= c.norm_x;
        corner_if.norm_y <= c.norm_y;
        corner_if.norm_z <= c.norm_z;
    endtask

    // Offer one corner, wait for the handshake, then predict from it.
    // Valid stays high into the next corner unless a gap is drawn.
    task automatic send_corner(t_corner c, bit typed = 1'b0, t_frame want = NO_FRAME);
        t_frame predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            corner_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        corner_if.valid <= 1'b1;
        drive_corner(c);
        do @(posedge i_clk); while (!(corner_if.valid && corner_if.ready));
        corners_taken++;
        if (frame_for_corner(c, predicted))
            pending_frames.insert(pending_frames.size(), typed ? want : predicted);
    endtask

    // One triangle of random content; a few are cut short to shift the corner count.
    task automatic send_random_triangle();
        t_corner tri_c [3];
        int      style;
        bit      wide;
        style = $urandom_range(9);
        wide  = (style == 4 || style == 5 || style == 9);
        for (int k = 0; k < 3; k++) begin
            if (style == 7)
                tri_c[k] = corner(pick_extreme(POS_LO, POS_HI), pick_extreme(POS_LO, POS_HI),
                                  pick_extreme(POS_LO, POS_HI), pick_extreme(TEX_LO, TEX_HI),
                                  pick_extreme(TEX_LO, TEX_HI),
                                  pick_extreme(-NRM_ONE, NRM_ONE),
                                  pick_extreme(-NRM_ONE, NRM_ONE),
                                  pick_extreme(-NRM_ONE, NRM_ONE));
            else if (wide)
                tri_c[k] = corner(rand_in(POS_LO, POS_HI), rand_in(POS_LO, POS_HI),
                                  rand_in(POS_LO, POS_HI), rand_in(TEX_LO, TEX_HI),
                                  rand_in(TEX_LO, TEX_HI), rand_in(-NRM_ONE, NRM_ONE),
                                  rand_in(-NRM_ONE, NRM_ONE), rand_in(-NRM_ONE, NRM_ONE));
            else
                tri_c[k] = corner(rand_in(-SMALL_POS, SMALL_POS),
                                  rand_in(-SMALL_POS, SMALL_POS),
                                  rand_in(-SMALL_POS, SMALL_POS), rand_in(-NRM_ONE, NRM_ONE),
                                  rand_in(-NRM_ONE, NRM_ONE), rand_in(-NRM_ONE, NRM_ONE),
                                  rand_in(-NRM_ONE, NRM_ONE), rand_in(-NRM_ONE, NRM_ONE));
        end
        if (style == 6) begin
            // zero determinant: one edge with no UV extent
            if ($urandom_range(1)) begin
                tri_c[0].tex_u = tri_c[1].tex_u;
                tri_c[0].tex_v = tri_c[1].tex_v;
            end else begin
                tri_c[2].tex_u = tri_c[1].tex_u;
                tri_c[2].tex_v = tri_c[1].tex_v;
            end
        end else if (style == 8) begin
            // tiny UV edges: small determinant, tangent may be driven into saturation
            tri_c[0].tex_u = tri_c[1].tex_u + TEX_W'(rand_in(-3, 3));
            tri_c[0].tex_v = tri_c[1].tex_v + TEX_W'(rand_in(-3, 3));
            tri_c[2].tex_u = tri_c[1].tex_u + TEX_W'(rand_in(-3, 3));
            tri_c[2].tex_v = tri_c[1].tex_v + TEX_W'(rand_in(-3, 3));
        end
        if (style == 9) begin
            for (int k = 0; k <= int'($urandom_range(1)); k++)
                send_corner(tri_c[k]);
        end else begin
            for (int k = 0; k < 3; k++)
                send_corner(tri_c[k]);
        end
    endtask

    // Result side: check each accepted frame, then draw ready for the next cycle.
    initial begin : frame_sink
        int hold_left;
        logic signed [OUT_W-1:0] got_v [7];
        logic signed [OUT_W-1:0] want_v [7];
        t_frame want;
        hold_left = 0;
        frame_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && frame_if.valid && frame_if.ready) begin
                if (pending_frames.size() == 0) begin
                    report_error("frame arrived with no triangle pending");
                end else begin
                    want = pending_frames.pop_front();
                    got_v  = '{frame_if.tangent_x, frame_if.tangent_y, frame_if.tangent_z,
                               frame_if.bitangent_x, frame_if.bitangent_y,
                               frame_if.bitangent_z, OUT_W'(frame_if.degenerate)};
                    want_v = '{want.tan_x, want.tan_y, want.tan_z, want.bit_x, want.bit_y,
                               want.bit_z, OUT_W'(want.degenerate)};
                    for (int i = 0; i < 7; i++)
                        if (got_v[i] !== want_v[i])
                            report_error($sformatf("%s got %0d expected %0d",
                                                   field_name[i], got_v[i], want_v[i]));
                    if (want.degenerate)
                        degenerate_seen++;
                    if (want.tan_x inside {OUT_MIN, OUT_MAX} ||
                        want.tan_y inside {OUT_MIN, OUT_MAX} ||
                        want.tan_z inside {OUT_MIN, OUT_MAX})
                        saturated_seen++;
                    frames_checked++;
                end
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                frame_if.ready <= 1'b0;
            end else begin
                frame_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // End the run when no item moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((corner_if.valid && corner_if.ready) || (frame_if.valid && frame_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no item moved for %0d cycles, %0d frames still pending",
                 STALL_LIMIT, pending_frames.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : corner_source
        errors          = 0;
        corners_taken   = 0;
        frames_checked  = 0;
        degenerate_seen = 0;
        saturated_seen  = 0;
        hold_request    = 1'b0;
        corners_held    = 0;
        send_idle_pct   = 27;
        recv_idle_pct   = 80;
        i_rst_n         <= 1'b0;
        corner_if.valid <= 1'b0;
        drive_corner('0);

        // Directed triangles, three corners each. A and C normals are junk on purpose.
        // All UVs equal: zero determinant.
        add_row(corner(1000, 2000, 3000, 4096, 4096, 0, 0, 0), 1'b0, NO_FRAME);
        add_row(corner(-500, 10, 7, 4096, 4096, NRM_ONE, 0, 0), 1'b0, NO_FRAME);
        add_row(corner(0, 0, 0, 4096, 4096, -77, 5, 9), 1'b1, DEGENERATE_FRAME);
        // Collinear UVs with extreme positions: zero determinant.
        add_row(corner(POS_HI, POS_LO, POS_HI, 0, 0, 1, 2, 3), 1'b0, NO_FRAME);
        add_row(corner(POS_LO, POS_HI, 0, 8192, 8192, 0, NRM_ONE, 0), 1'b0, NO_FRAME);
        add_row(corner(POS_HI, POS_HI, POS_LO, 16384, 16384, 4, 5, 6),
                1'b1, DEGENERATE_FRAME);
        // Full-scale edges over a unit determinant: tangent and bitangent clamp.
        add_row(corner(POS_HI, POS_HI, POS_HI, 1, 0, -NRM_ONE, 9, -9), 1'b0, NO_FRAME);
        add_row(corner(POS_LO, POS_LO, POS_LO, 0, 0, NRM_ONE, -NRM_ONE, 0),
                1'b0, NO_FRAME);
        add_row(corner(POS_HI, POS_HI, POS_HI, 0, 1, 123, -456, 789),
                1'b1, SATURATED_FRAME);
        // Mirror of the above with extreme texcoords and a -1.0 normal.
        add_row(corner(POS_LO, POS_LO, POS_LO, TEX_HI, TEX_LO, 0, 0, 0), 1'b0, NO_FRAME);
        add_row(corner(POS_HI, POS_HI, POS_HI, TEX_LO, TEX_HI,
                       -NRM_ONE, -NRM_ONE, -NRM_ONE), 1'b0, NO_FRAME);
        add_row(corner(POS_LO, POS_LO, POS_LO, TEX_HI, TEX_HI, 0, 0, 0), 1'b0, NO_FRAME);
        // Determinant 2^19 with odd numerators: rounding ties in both stages.
        add_row(corner(100, 0, 0, 16384, 1, 0, 0, 0), 1'b0, NO_FRAME);
        add_row(corner(0, 0, 0, -16384, 0, 8192, 0, 0), 1'b0, NO_FRAME);
        add_row(corner(3, 5, -7, -16384, 16, 0, 0, 0), 1'b0, NO_FRAME);
        // Negative determinant, unit-scale triangle.
        add_row(corner(4096, 0, 0, 0, 16384, NRM_ONE, NRM_ONE, NRM_ONE), 1'b0, NO_FRAME);
        add_row(corner(0, 0, 0, 0, 0, 0, 0, NRM_ONE), 1'b0, NO_FRAME);
        add_row(corner(0, 4096, 0, 16384, 0, -NRM_ONE, -NRM_ONE, -NRM_ONE),
                1'b0, NO_FRAME);
        // Largest UV extents with mixed extreme positions and normals.
        add_row(corner(POS_HI, 0, POS_LO, TEX_LO, TEX_LO, 0, 0, 0), 1'b0, NO_FRAME);
        add_row(corner(0, POS_LO, POS_HI, TEX_HI, TEX_LO,
                       NRM_ONE, NRM_ONE, -NRM_ONE), 1'b0, NO_FRAME);
        add_row(corner(-1, POS_HI, 1, TEX_HI, TEX_HI, 0, 0, 0), 1'b0, NO_FRAME);
        // Tiny values around zero.
        add_row(corner(-1, -1, -1, -1, -1, -NRM_ONE, -NRM_ONE, -NRM_ONE), 1'b0, NO_FRAME);
        add_row(corner(1, 1, 1, 1, -1, -1, -1, -1), 1'b0, NO_FRAME);
        add_row(corner(0, 0, 0, -1, 1, NRM_ONE, NRM_ONE, NRM_ONE), 1'b0, NO_FRAME);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 1: sender idles a little, receiver a lot.
        foreach (directed_rows[i])
            send_corner(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
        while (corners_taken < ITEMS_PHASE_1)
            send_random_triangle();

        // Phase 2: the other way round.
        send_idle_pct = 80;
        recv_idle_pct = 27;
        while (corners_taken < ITEMS_PHASE_2)
            send_random_triangle();

        // Phase 3: no idling; open with a long output stall so the block backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        while (corners_taken < ITEMS_TOTAL)
            send_random_triangle();
        corner_if.valid <= 1'b0;

        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d corners and %0d frames: %0d degenerate, %0d %s",
                 corners_taken, frames_checked, degenerate_seen, saturated_seen,
                 "with a clamped tangent,");
        $display("under three idle mixes and one %0d-cycle output stall; %0d mismatches.",
                 HOLD_CYCLES, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
